### rtl/sha224_pkg.sv
// Shared types, constants and SHA-256 round functions for the SHA-224 digest block.
// Depends on nothing; every other file in this folder imports it.
package sha224_pkg;

    typedef logic [31:0]       word_t;
    typedef logic [7:0][31:0]  state8_t;   // index 0 is working variable a
    typedef logic [15:0][31:0] window_t;   // index 0 is the oldest word

    typedef struct packed {
        logic  push;
        word_t word;
    } push_t;

    typedef struct packed {
        logic       busy;
        logic [3:0] fill;
    } core_status_t;

    localparam logic [2:0] LAST_DIGEST_IDX = 3'd6;
    localparam logic [3:0] LEN_SLOT_FILL   = 4'd14;
    localparam logic [3:0] FULL_FILL       = 4'd15;
    localparam logic [5:0] LAST_ROUND      = 6'd63;
    localparam word_t      PAD_WORD        = 32'h8000_0000;

    localparam state8_t INIT_HASH = {
        32'hBEFA4FA4, 32'h64F98FA7, 32'h68581511, 32'hFFC00B31,
        32'hF70E5939, 32'h3070DD17, 32'h367CD507, 32'hC1059ED8
    };

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428A2F98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hB5C0FBCF;
            6'd3:  round_k = 32'hE9B5DBA5;
            6'd4:  round_k = 32'h3956C25B;
            6'd5:  round_k = 32'h59F111F1;
            6'd6:  round_k = 32'h923F82A4;
            6'd7:  round_k = 32'hAB1C5ED5;
            6'd8:  round_k = 32'hD807AA98;
            6'd9:  round_k = 32'h12835B01;
            6'd10: round_k = 32'h243185BE;
            6'd11: round_k = 32'h550C7DC3;
            6'd12: round_k = 32'h72BE5D74;
            6'd13: round_k = 32'h80DEB1FE;
            6'd14: round_k = 32'h9BDC06A7;
            6'd15: round_k = 32'hC19BF174;
            6'd16: round_k = 32'hE49B69C1;
            6'd17: round_k = 32'hEFBE4786;
            6'd18: round_k = 32'h0FC19DC6;
            6'd19: round_k = 32'h240CA1CC;
            6'd20: round_k = 32'h2DE92C6F;
            6'd21: round_k = 32'h4A7484AA;
            6'd22: round_k = 32'h5CB0A9DC;
            6'd23: round_k = 32'h76F988DA;
            6'd24: round_k = 32'h983E5152;
            6'd25: round_k = 32'hA831C66D;
            6'd26: round_k = 32'hB00327C8;
            6'd27: round_k = 32'hBF597FC7;
            6'd28: round_k = 32'hC6E00BF3;
            6'd29: round_k = 32'hD5A79147;
            6'd30: round_k = 32'h06CA6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27B70A85;
            6'd33: round_k = 32'h2E1B2138;
            6'd34: round_k = 32'h4D2C6DFC;
            6'd35: round_k = 32'h53380D13;
            6'd36: round_k = 32'h650A7354;
            6'd37: round_k = 32'h766A0ABB;
            6'd38: round_k = 32'h81C2C92E;
            6'd39: round_k = 32'h92722C85;
            6'd40: round_k = 32'hA2BFE8A1;
            6'd41: round_k = 32'hA81A664B;
            6'd42: round_k = 32'hC24B8B70;
            6'd43: round_k = 32'hC76C51A3;
            6'd44: round_k = 32'hD192E819;
            6'd45: round_k = 32'hD6990624;
            6'd46: round_k = 32'hF40E3585;
            6'd47: round_k = 32'h106AA070;
            6'd48: round_k = 32'h19A4C116;
            6'd49: round_k = 32'h1E376C08;
            6'd50: round_k = 32'h2748774C;
            6'd51: round_k = 32'h34B0BCB5;
            6'd52: round_k = 32'h391C0CB3;
            6'd53: round_k = 32'h4ED8AA4A;
            6'd54: round_k = 32'h5B9CCA4F;
            6'd55: round_k = 32'h682E6FF3;
            6'd56: round_k = 32'h748F82EE;
            6'd57: round_k = 32'h78A5636F;
            6'd58: round_k = 32'h84C87814;
            6'd59: round_k = 32'h8CC70208;
            6'd60: round_k = 32'h90BEFFFA;
            6'd61: round_k = 32'hA4506CEB;
            6'd62: round_k = 32'hBEF9A3F7;
            6'd63: round_k = 32'hC67178F2;
            default: round_k = 32'h0000_0000;
        endcase
    endfunction

endpackage

### rtl/sha224_if.sv
// Valid/ready channel interfaces for message words in and digest words out.
// Depends on sha224_pkg for the word type.
interface sha224_in_if;
    import sha224_pkg::*;

    logic       valid;
    logic       ready;
    word_t      data_word;
    logic [2:0] byte_count;
    logic       last_word;

    modport source (output valid, output data_word, output byte_count, output last_word,
                    input ready);
    modport sink   (input valid, input data_word, input byte_count, input last_word,
                    output ready);
endinterface

interface sha224_out_if;
    import sha224_pkg::*;

    logic       valid;
    logic       ready;
    word_t      digest_word;
    logic [2:0] word_index;
    logic       digest_last;

    modport source (output valid, output digest_word, output word_index, output digest_last,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input digest_last,
                    output ready);
endinterface

### rtl/sha224_round.sv
// One SHA-256 compression round: the shared arithmetic unit of the core.
// Depends on sha224_pkg.
module sha224_round (
    input  sha224_pkg::state8_t v,
    input  sha224_pkg::word_t   w,
    input  sha224_pkg::word_t   k,
    output sha224_pkg::state8_t v_next
);
    import sha224_pkg::*;

    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;

    always_comb
    begin
        ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
        maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t1  = v[7] + big_sigma1(v[4]) + ch + k + w;
        t2  = big_sigma0(v[0]) + maj;
        v_next[7] = v[6];
        v_next[6] = v[5];
        v_next[5] = v[4];
        v_next[4] = v[3] + t1;
        v_next[3] = v[2];
        v_next[2] = v[1];
        v_next[1] = v[0];
        v_next[0] = t1 + t2;
    end

endmodule

### rtl/sha224_core.sv
// Compression engine: 16-word block window, message schedule, round sequencer and chain.
// Depends on sha224_pkg and sha224_round.
module sha224_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sha224_pkg::push_t        push,
    input  logic                     restart,
    output sha224_pkg::core_status_t status,
    output sha224_pkg::state8_t      chain
);
    import sha224_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} core_state_t;

    core_state_t state_reg;
    logic [3:0]  fill_reg;
    logic [5:0]  round_reg;
    state8_t     chain_reg;
    state8_t     work_reg;
    window_t     window_reg;

    state8_t     round_out;
    state8_t     chain_sum;
    word_t       sched_word;

    sha224_round u_round (
        .v      (work_reg),
        .w      (window_reg[0]),
        .k      (round_k(round_reg)),
        .v_next (round_out)
    );

    // next schedule word w[t+16] from the taps of the window
    assign sched_word = small_sigma1(window_reg[14]) + window_reg[9]
                      + small_sigma0(window_reg[1]) + window_reg[0];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            chain_sum[i] = chain_reg[i] + work_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            fill_reg  <= '0;
            round_reg <= '0;
            chain_reg <= INIT_HASH;
        end
        else
        begin
            case (state_reg)
                C_IDLE:
                begin
                    if (restart)
                    begin
                        chain_reg <= INIT_HASH;
                    end
                    if (push.push)
                    begin
                        fill_reg <= fill_reg + 4'd1;
                        if (fill_reg == FULL_FILL)
                        begin
                            round_reg <= '0;
                            state_reg <= C_ROUND;
                        end
                    end
                end
                C_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == LAST_ROUND)
                    begin
                        state_reg <= C_FINAL;
                    end
                end
                C_FINAL:
                begin
                    chain_reg <= chain_sum;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // datapath: window shift line and working variables
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && push.push)
        begin
            window_reg <= {push.word, window_reg[15:1]};
            if (fill_reg == FULL_FILL)
            begin
                work_reg <= chain_reg;
            end
        end
        else if (state_reg == C_ROUND)
        begin
            window_reg <= {sched_word, window_reg[15:1]};
            work_reg   <= round_out;
        end
    end

    assign status.busy = (state_reg != C_IDLE);
    assign status.fill = fill_reg;
    assign chain       = chain_reg;

`ifndef SYNTHESIS
    a_no_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> state_reg == C_IDLE)
        else $error("word pushed while compression is running");

    a_round_to_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_ROUND && round_reg == LAST_ROUND) |=> state_reg == C_FINAL)
        else $error("last round not followed by chain update");

    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_IDLE && push.push && fill_reg == FULL_FILL)
        |=> (state_reg == C_ROUND && round_reg == 6'd0 && fill_reg == 4'd0))
        else $error("full block did not start compression");
`endif

endmodule

### rtl/sha224_pad.sv
// Message sequencer: block filling, 0x80 padding, zero fill and bit-length words.
// Depends on sha224_pkg.
module sha224_pad (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  sha224_pkg::word_t        data_word,
    input  logic [2:0]               byte_count,
    input  logic                     last_word,
    input  sha224_pkg::core_status_t status,
    output sha224_pkg::push_t        push,
    output logic                     idle,
    output logic                     finish
);
    import sha224_pkg::*;

    typedef enum logic [2:0] {P_IDLE, P_PAD, P_ZERO, P_LEN_HI, P_LEN_LO, P_WAIT} pad_state_t;

    pad_state_t  state_reg;
    logic [63:0] bytes_reg;

    logic [2:0]  count_sat;
    word_t       tail_word;
    logic [63:0] bit_len;

    assign count_sat = (byte_count > 3'd4) ? 3'd4 : byte_count;
    assign bit_len   = {bytes_reg[60:0], 3'b000};

    // keep the valid upper bytes, append the 0x80 marker byte; a full word passes unchanged
    always_comb
    begin
        case (count_sat)
            3'd0:    tail_word = PAD_WORD;
            3'd1:    tail_word = {data_word[31:24], 24'h80_0000};
            3'd2:    tail_word = {data_word[31:16], 16'h8000};
            3'd3:    tail_word = {data_word[31:8], 8'h80};
            default: tail_word = data_word;
        endcase
    end

    always_comb
    begin
        push.push = 1'b0;
        push.word = '0;
        case (state_reg)
            P_IDLE:
            begin
                push.push = accept;
                push.word = last_word ? tail_word : data_word;
            end
            P_PAD:
            begin
                push.push = !status.busy;
                push.word = PAD_WORD;
            end
            P_ZERO:
            begin
                push.push = !status.busy && (status.fill != LEN_SLOT_FILL);
            end
            P_LEN_HI:
            begin
                push.push = !status.busy;
                push.word = bit_len[63:32];
            end
            P_LEN_LO:
            begin
                push.push = !status.busy;
                push.word = bit_len[31:0];
            end
            default:
            begin
                push.push = 1'b0;
            end
        endcase
    end

    assign idle   = (state_reg == P_IDLE);
    assign finish = (state_reg == P_WAIT) && !status.busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            bytes_reg <= '0;
        end
        else
        begin
            case (state_reg)
                P_IDLE:
                begin
                    if (accept)
                    begin
                        if (!last_word)
                        begin
                            bytes_reg <= bytes_reg + 64'd4;
                        end
                        else
                        begin
                            bytes_reg <= bytes_reg + {61'd0, count_sat};
                            state_reg <= (count_sat == 3'd4) ? P_PAD : P_ZERO;
                        end
                    end
                end
                P_PAD:
                begin
                    if (!status.busy)
                    begin
                        state_reg <= P_ZERO;
                    end
                end
                P_ZERO:
                begin
                    if (!status.busy && status.fill == LEN_SLOT_FILL)
                    begin
                        state_reg <= P_LEN_HI;
                    end
                end
                P_LEN_HI:
                begin
                    if (!status.busy)
                    begin
                        state_reg <= P_LEN_LO;
                    end
                end
                P_LEN_LO:
                begin
                    if (!status.busy)
                    begin
                        state_reg <= P_WAIT;
                    end
                end
                P_WAIT:
                begin
                    if (!status.busy)
                    begin
                        bytes_reg <= '0;
                        state_reg <= P_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/sha224_message_digest.sv
// SHA-224 digest over big-endian 32-bit words, one compression round per cycle.
// A word that completes a block holds ready low for the 64 rounds and the chain add.
// Last word: up to 17 padding pushes, one per cycle while the core is not busy, plus one or two
// compressions, then seven digest transactions at one per cycle while the receiver holds ready
// high. Reset clears all control state and loads the SHA-224 initial hash; the block
// buffer is not cleared. Depends on sha224_pkg, sha224_if, sha224_pad, sha224_core, sha224_round.
module sha224_message_digest (
    input  logic         clk,
    input  logic         rst_n,
    sha224_in_if.sink    msg,
    sha224_out_if.source digest
);
    import sha224_pkg::*;

    push_t        push;
    core_status_t status;
    state8_t      chain;
    logic         pad_idle;
    logic         finish;
    logic         in_accept;
    logic         out_accept;
    logic         restart;

    logic         emit_active_reg;
    logic [2:0]   idx_reg;
    word_t        word_reg;
    logic [2:0]   idx_next;

    // Take a message word only when the padding sequencer rests, the core is not
    // compressing and no digest is draining.
    assign msg.ready  = pad_idle && !status.busy && !emit_active_reg;
    assign in_accept  = msg.valid && msg.ready;
    assign out_accept = digest.valid && digest.ready;

    // Drop the chain back to the initial hash once the final digest word leaves.
    assign restart  = out_accept && (idx_reg == LAST_DIGEST_IDX);
    assign idx_next = idx_reg + 3'd1;

    sha224_pad u_pad (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .data_word  (msg.data_word),
        .byte_count (msg.byte_count),
        .last_word  (msg.last_word),
        .status     (status),
        .push       (push),
        .idle       (pad_idle),
        .finish     (finish)
    );

    sha224_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .restart (restart),
        .status  (status),
        .chain   (chain)
    );

    // Digest emitter: hold each word until its transaction completes, then advance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_active_reg <= 1'b0;
            idx_reg         <= '0;
        end
        else
        begin
            if (finish)
            begin
                emit_active_reg <= 1'b1;
                idx_reg         <= '0;
            end
            else if (out_accept)
            begin
                if (idx_reg == LAST_DIGEST_IDX)
                begin
                    emit_active_reg <= 1'b0;
                    idx_reg         <= '0;
                end
                else
                begin
                    idx_reg <= idx_next;
                end
            end
        end
    end

    // Output word register, loaded from the chain value of the finished message.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            word_reg <= chain[0];
        end
        else if (out_accept && idx_reg != LAST_DIGEST_IDX)
        begin
            word_reg <= chain[idx_next];
        end
    end

    assign digest.valid       = emit_active_reg;
    assign digest.digest_word = word_reg;
    assign digest.word_index  = idx_reg;
    assign digest.digest_last = (idx_reg == LAST_DIGEST_IDX);

`ifndef SYNTHESIS
    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && digest.digest_last) |=> !digest.valid)
        else $error("digest stream continued past the final word");

    a_finish_core_idle: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (!status.busy && !emit_active_reg))
        else $error("digest started while core busy or previous digest draining");
`endif

endmodule

### dv/sha224_digest_checker.sv
// Watches both channels of the SHA-224 digest block, predicts every digest word and
// compares it with what the block hands out. Depends on sha224_pkg and sha224_if.
module sha224_digest_checker (
    input  logic  clk,
    input  logic  rst_n,
    sha224_in_if  msg,
    sha224_out_if digest,
    output int    fails,
    output int    pending
);
    import sha224_pkg::*;

    localparam logic [0:63][31:0] ROUND_KEYS = {
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [0:7][31:0] START_CHAIN = {
        32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
        32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
    };

    localparam logic [31:0] END_MARKER   = 32'h8000_0000;
    localparam logic [2:0]  FINAL_INDEX  = 3'd6;
    localparam logic [2:0]  FULL_WORD    = 3'd4;
    localparam logic [3:0]  LENGTH_SLOT  = 4'd14;

    typedef struct {
        word_t      word;
        logic [2:0] index;
        logic       last;
    } digest_beat_t;

    digest_beat_t digest_queue[$];
    digest_beat_t oldest;

    word_t       chain [8];
    word_t       block_buf [16];
    logic [3:0]  block_fill;
    logic [63:0] byte_total;

    task automatic report(input string note);
        $display("ERROR %0t: %s", $time, note);
        fails++;
    endtask

    function automatic word_t ror(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++)
            chain[i] = START_CHAIN[i];
        block_fill = '0;
        byte_total = '0;
    endfunction

    function automatic void compress_block();
        word_t sched [64];
        word_t v [8];
        word_t t1;
        word_t t2;
        for (int t = 0; t < 16; t++)
            sched[t] = block_buf[t];
        for (int t = 16; t < 64; t++)
            sched[t] = (ror(sched[t-2], 17) ^ ror(sched[t-2], 19) ^ (sched[t-2] >> 10))
                     + sched[t-7]
                     + (ror(sched[t-15], 7) ^ ror(sched[t-15], 18) ^ (sched[t-15] >> 3))
                     + sched[t-16];
        for (int i = 0; i < 8; i++)
            v[i] = chain[i];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_KEYS[t] + sched[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endfunction

    function automatic void absorb(input word_t w);
        block_buf[block_fill] = w;
        block_fill = block_fill + 4'd1;
        if (block_fill == 4'd0)
            compress_block();
    endfunction

    // Pad the tail, append the bit length and queue the seven digest words.
    function automatic void close_message(input word_t data, input logic [2:0] count);
        logic [2:0]   n;
        word_t        keep;
        logic [63:0]  bit_len;
        digest_beat_t beat;
        n = (count > FULL_WORD) ? FULL_WORD : count;
        byte_total = byte_total + 64'(n);
        if (n == FULL_WORD)
        begin
            absorb(data);
            absorb(END_MARKER);
        end
        else
        begin
            keep = (n == 3'd0) ? '0 : ~(32'hFFFF_FFFF >> (8 * n));
            absorb((data & keep) | (END_MARKER >> (8 * n)));
        end
        if (block_fill > LENGTH_SLOT)
            while (block_fill != 4'd0)
                absorb('0);
        while (block_fill < LENGTH_SLOT)
            absorb('0);
        bit_len = byte_total << 3;
        absorb(bit_len[63:32]);
        absorb(bit_len[31:0]);
        for (int k = 0; k < 7; k++)
        begin
            beat.word  = chain[k];
            beat.index = 3'(k);
            beat.last  = (3'(k) == FINAL_INDEX);
            digest_queue.push_back(beat);
        end
        restart_message();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_message();
            digest_queue.delete();
        end
        else
        begin
            if (digest.valid && digest.ready)
            begin
                if (digest_queue.size() == 0)
                    report($sformatf("digest word %h with nothing expected",
                                     digest.digest_word));
                else
                begin
                    oldest = digest_queue.pop_front();
                    if (digest.digest_word !== oldest.word)
                        report($sformatf("digest_word expected %h got %h",
                                         oldest.word, digest.digest_word));
                    if (digest.word_index !== oldest.index)
                        report($sformatf("word_index expected %0d got %0d",
                                         oldest.index, digest.word_index));
                    if (digest.digest_last !== oldest.last)
                        report($sformatf("digest_last expected %0b got %0b",
                                         oldest.last, digest.digest_last));
                end
            end
            if (msg.valid && msg.ready)
            begin
                if (msg.last_word)
                    close_message(msg.data_word, msg.byte_count);
                else
                begin
                    byte_total = byte_total + 64'd4;
                    absorb(msg.data_word);
                end
            end
        end
        pending = digest_queue.size();
    end

endmodule

### dv/testbench.sv
// Top of the SHA-224 digest testbench: clock, reset, message stimulus, digest back-pressure
// and the verdict. Depends on sha224_pkg, sha224_if, the block and sha224_digest_checker.
module testbench;
    import sha224_pkg::*;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Idle odds in percent per cycle for each side; the stimulus changes them by phase.
    int send_idle_pct;
    int recv_idle_pct;

    // Count of accepted message words, used to step through the idling phases.
    int words_sent = 0;

    int fails;
    int pending;

    sha224_in_if  msg_ch();
    sha224_out_if digest_ch();

    sha224_message_digest dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (digest_ch)
    );

    // The checker sees every transaction on both channels and keeps the expected digests.
    sha224_digest_checker digest_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg_ch),
        .digest  (digest_ch),
        .fails   (fails),
        .pending (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the digest side at random; hold ready low while reset is active.
    always @(posedge clk)
    begin
        digest_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Mostly random words, with the all-zero and all-one patterns mixed in.
    function automatic word_t pick_word();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 32'h0000_0000;
        if (sel == 1)
            return 32'hFFFF_FFFF;
        return word_t'($urandom);
    endfunction

    // Present one message word and hold it until the block takes the transaction.
    // Drop valid for random idle cycles first, then drive the payload once.
    task automatic send_word(input word_t data, input logic [2:0] count, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid      <= 1'b1;
        msg_ch.data_word  <= data;
        msg_ch.byte_count <= count;
        msg_ch.last_word  <= last;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    initial
    begin
        int body;
        msg_ch.valid      = 1'b0;
        msg_ch.data_word  = '0;
        msg_ch.byte_count = '0;
        msg_ch.last_word  = 1'b0;
        // First phase: the sender idles less often than the receiver stalls.
        send_idle_pct = 27;
        recv_idle_pct = 55;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed messages. Start with the empty message: a lone last word with no bytes.
        send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
        // One full last word, then partial last words whose unused low bytes must be cleared.
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
        send_word(32'hA5A5_A5A5, 3'd2, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd3, 1'b1);
        // Byte counts above four saturate to a full word.
        send_word(32'h1234_5678, 3'd7, 1'b1);
        // A byte count on a non-last word is ignored; the word counts as four bytes.
        send_word(32'h0000_0000, 3'd7, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd6, 1'b1);
        send_word(32'h0000_0000, 3'd0, 1'b0);
        send_word(pick_word(), 3'd3, 1'b0);
        send_word(32'h0000_0000, 3'd0, 1'b1);
        // Thirteen words plus a full last word leave no room for the length: extra block.
        for (int i = 0; i < 13; i++)
            send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
        send_word(pick_word(), 3'd4, 1'b1);

        // Random messages: mostly short ones that land the tail anywhere in a block,
        // a few that span two or three blocks.
        while (words_sent < 370)
        begin
            if (words_sent >= 250)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (words_sent >= 130)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 27;
            end
            body = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                : $urandom_range(0, 16);
            for (int i = 0; i < body; i++)
                send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
            send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b1);
        end
        msg_ch.valid <= 1'b0;

        // Drain: wait for every expected digest word, then let the block settle.
        do
            @(posedge clk);
        while (pending != 0);
        repeat (100) @(posedge clk);

        // Leftover expectations count as a failure too.
        if (fails == 0 && pending == 0)
            $display("PASS sha224_message_digest");
        else
            $display("FAIL sha224_message_digest");
        $finish;
    end

    // Watchdog: a correct run needs a small fraction of this time.
    initial
    begin
        #3000000;
        $display("FAIL sha224_message_digest");
        $finish;
    end

endmodule

### filelist.f
rtl/sha224_pkg.sv
rtl/sha224_if.sv
rtl/sha224_round.sv
rtl/sha224_core.sv
rtl/sha224_pad.sv
rtl/sha224_message_digest.sv
dv/sha224_digest_checker.sv
dv/testbench.sv
